// ===== rtl/xlb_pkg.sv =====
package xlb_pkg;

    // Fixed field widths
    localparam int VAL_W  = 63;
    localparam int RANK_W = 6;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REDUCE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new transaction, read the top slot
        logic step;   // process the current slot, advance to the next one
    } xlb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic store_hit;  // insert lands on an empty slot this cycle
        logic last;       // current slot is slot zero
    } xlb_status_t;

endpackage

// ===== rtl/xlb_ctrl.sv =====
module xlb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  xlb_pkg::xlb_status_t status,
    output xlb_pkg::xlb_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.store_hit || status.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ===== rtl/xlb_datapath.sv =====
module xlb_datapath
#(
    parameter int WIDTH = 63
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  xlb_pkg::xlb_cmd_t          cmd,
    input  logic                       action,
    input  logic [xlb_pkg::VAL_W-1:0]  value,
    output xlb_pkg::xlb_status_t       status,
    output logic [xlb_pkg::VAL_W-1:0]  result_value,
    output logic                       was_inserted,
    output logic [xlb_pkg::RANK_W-1:0] basis_rank
);

    localparam int NSLOT = (WIDTH >= xlb_pkg::VAL_W) ? xlb_pkg::VAL_W : WIDTH;
    localparam int IDXW  = $clog2(NSLOT);
    localparam logic [IDXW-1:0] TOP_SLOT = IDXW'(NSLOT - 1);
    localparam logic [xlb_pkg::VAL_W-1:0] VAL_MASK = (WIDTH >= xlb_pkg::VAL_W) ?
        {xlb_pkg::VAL_W{1'b1}} : xlb_pkg::VAL_W'((64'd1 << WIDTH) - 64'd1);

    logic [xlb_pkg::VAL_W-1:0] basis_mem [NSLOT];
    logic [xlb_pkg::VAL_W-1:0] rd_data_reg;
    logic [IDXW-1:0]           rd_addr;

    logic                       action_reg;
    logic                       action_next;
    logic [xlb_pkg::VAL_W-1:0]  val_reg;
    logic [xlb_pkg::VAL_W-1:0]  val_next;
    logic [IDXW-1:0]            idx_reg;
    logic [IDXW-1:0]            idx_next;
    logic                       placed_reg;
    logic                       placed_next;
    logic [xlb_pkg::RANK_W-1:0] rank_reg;
    logic [xlb_pkg::RANK_W-1:0] rank_next;
    logic [NSLOT-1:0]           valid_reg;
    logic [NSLOT-1:0]           valid_next;

    logic bit_set;
    logic slot_full;
    logic mem_we;

    assign bit_set   = val_reg[idx_reg];
    assign slot_full = valid_reg[idx_reg];

    assign status.store_hit = (action_reg == xlb_pkg::ACT_INSERT) && bit_set && !slot_full;
    assign status.last      = (idx_reg == '0);

    assign mem_we = cmd.step && status.store_hit;

    // Read the top slot on load, then one slot ahead of the walk
    always_comb
    begin
        if (cmd.load || status.last)
        begin
            rd_addr = TOP_SLOT;
        end
        else
        begin
            rd_addr = idx_reg - IDXW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            basis_mem[idx_reg] <= val_reg;
        end
        rd_data_reg <= basis_mem[rd_addr];
    end

    always_comb
    begin
        action_next = action_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        placed_next = placed_reg;
        rank_next   = rank_reg;
        valid_next  = valid_reg;
        if (cmd.load)
        begin
            action_next = action;
            val_next    = value & VAL_MASK;
            idx_next    = TOP_SLOT;
            placed_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (status.store_hit)
            begin
                valid_next[idx_reg] = 1'b1;
                placed_next         = 1'b1;
                rank_next           = rank_reg + xlb_pkg::RANK_W'(1);
            end
            else if (bit_set && slot_full)
            begin
                val_next = val_reg ^ rd_data_reg;
            end
            if (!status.last)
            begin
                idx_next = idx_reg - IDXW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rank_reg   <= '0;
            placed_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rank_reg   <= rank_next;
            placed_reg <= placed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
    end

    assign result_value = ((action_reg == xlb_pkg::ACT_REDUCE) || placed_reg) ? val_reg : '0;
    assign was_inserted = placed_reg;
    assign basis_rank   = rank_reg;

endmodule

// ===== rtl/xor_linear_basis_engine_top.sv =====
// Timing: a transaction walks the slots from the top down, at most to slot zero, before done strobes;
//   an insert that lands early in the walk finishes sooner.
// Throughput: one transaction at a time, set by the walk that reads one basis slot per cycle
//   from the single read port of the slot memory; start is taken only while idle.
// Reset: rst_n clears the slot valid flags, the rank and the controller at once; no sweep.
//   The receiver cannot stall: done is a one-cycle strobe.
module xor_linear_basis_engine_top
#(
    parameter int WIDTH = 63
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       action,
    input  logic [xlb_pkg::VAL_W-1:0]  value,
    output logic                       done,
    output logic [xlb_pkg::VAL_W-1:0]  result_value,
    output logic                       was_inserted,
    output logic [xlb_pkg::RANK_W-1:0] basis_rank
);

    // Command and status between the walk sequencer and the basis datapath
    xlb_pkg::xlb_cmd_t    cmd;
    xlb_pkg::xlb_status_t status;

    // Sequencer: idle, walk the slots from the top down, strobe the result
    xlb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath: working vector, slot memory with valid flags, rank counter.
    // A filled slot whose leading bit matches the vector is XORed in; an insert
    // that meets an empty slot at a set bit stores the vector there and stops the walk.
    xlb_datapath #(
        .WIDTH (WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .value        (value),
        .status       (status),
        .result_value (result_value),
        .was_inserted (was_inserted),
        .basis_rank   (basis_rank)
    );

endmodule

// ===== rtl/xlb_checker.sv =====
module xlb_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [xlb_pkg::VAL_W-1:0]  result_value,
    input logic                       was_inserted
);

    // Accepted transaction holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // Result strobe lasts one cycle and frees the block
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done not a single-cycle strobe followed by idle");

    // Strobe only while a transaction is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobed while idle");

    // A stored vector is never zero
    a_insert_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_inserted |-> result_value != '0)
        else $error("inserted vector reported as zero");

endmodule

bind xor_linear_basis_engine_top xlb_checker u_xlb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .was_inserted (was_inserted)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Basis width under test; the prediction follows it.
    localparam int BASIS_W      = 63;
    localparam int TOP_SLOT     = (BASIS_W >= 63) ? 62 : BASIS_W - 1;
    localparam int RANDOM_ITEMS = 500;
    // Worst case is about 520 transactions, each a full slot walk plus the longest gap, well under the limit.
    localparam int CYCLE_LIMIT  = 400000;
    // Keep the span source short so that span-built vectors stay cheap to form.
    localparam int SPAN_DEPTH   = 40;

    typedef logic [xlb_pkg::VAL_W-1:0] vec_t;

    localparam vec_t KEEP_MASK = (BASIS_W >= 63) ? {xlb_pkg::VAL_W{1'b1}}
                                 : xlb_pkg::VAL_W'((64'd1 << BASIS_W) - 64'd1);

    // One expected result of a transaction.
    typedef struct packed {
        vec_t                       vec;
        logic                       placed;
        logic [xlb_pkg::RANK_W-1:0] rank;
    } basis_outcome_t;

    // How a random vector is built.
    typedef enum int {
        SHAPE_NARROW,   // random bits below a random leading position
        SHAPE_SPARSE,   // one to three random bits
        SHAPE_SPAN,     // XOR of recent inserted vectors, so already in the span
        SHAPE_WIDE,     // all 63 bits random
        SHAPE_EDGE      // zero or all ones
    } vec_shape_t;

    // Hold a private copy of the basis, predict each transaction and check the results.
    class basis_scoreboard;
        vec_t                       rows [64];
        logic [xlb_pkg::RANK_W-1:0] rank;
        basis_outcome_t             pending [$];
        int unsigned                mismatches;

        function new();
            foreach (rows[i])
                rows[i] = '0;
            rank       = '0;
            mismatches = 0;
        endfunction

        task log_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        // Walk the slots from the top down and queue the outcome of one accepted transaction.
        function void note_input(logic act, vec_t val);
            vec_t           v;
            vec_t           stored;
            logic           placed;
            logic           walking;
            basis_outcome_t outcome;
            v       = val & KEEP_MASK;
            stored  = '0;
            placed  = 1'b0;
            walking = 1'b1;
            if (act == xlb_pkg::ACT_INSERT)
            begin
                for (int i = TOP_SLOT; i >= 0; i--)
                begin
                    if (walking && v[i])
                    begin
                        if (rows[i] == '0)
                        begin
                            rows[i] = v;
                            stored  = v;
                            placed  = 1'b1;
                            rank    = rank + 1'b1;
                            walking = 1'b0;
                        end
                        else
                        begin
                            v ^= rows[i];
                        end
                    end
                end
                outcome.vec = stored;
            end
            else
            begin
                for (int i = TOP_SLOT; i >= 0; i--)
                begin
                    if ((v ^ rows[i]) < v)
                        v ^= rows[i];
                end
                outcome.vec = v;
            end
            outcome.placed = placed;
            outcome.rank   = rank;
            pending.push_back(outcome);
        endfunction

        task check_result(vec_t vec, logic placed, logic [xlb_pkg::RANK_W-1:0] rank_seen);
            basis_outcome_t want;
            if (pending.size() == 0)
            begin
                log_mismatch($sformatf("result %h with no transaction outstanding", vec));
                return;
            end
            want = pending.pop_front();
            if (vec !== want.vec)
                log_mismatch($sformatf("result_value got %h expected %h", vec, want.vec));
            if (placed !== want.placed)
                log_mismatch($sformatf("was_inserted got %b expected %b", placed, want.placed));
            if (rank_seen !== want.rank)
                log_mismatch($sformatf("basis_rank got %0d expected %0d", rank_seen, want.rank));
        endtask
    endclass

    logic                       clk    = 1'b0;
    logic                       rst_n  = 1'b0;
    logic                       start  = 1'b0;
    logic                       action = 1'b0;
    vec_t                       value  = '0;
    logic                       busy;
    logic                       done;
    vec_t                       result_value;
    logic                       was_inserted;
    logic [xlb_pkg::RANK_W-1:0] basis_rank;

    basis_scoreboard basis_sb;
    vec_t            insert_log [$];
    int              burst_left = 0;
    int              cycles     = 0;

    xor_linear_basis_engine_top #(
        .WIDTH(BASIS_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .was_inserted (was_inserted),
        .basis_rank   (basis_rank)
    );

    always #1 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check every strobed result; values are sampled before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && done)
            basis_sb.check_result(result_value, was_inserted, basis_rank);
    end

    function automatic vec_t any_vec();
        return vec_t'({$urandom, $urandom});
    endfunction

    function automatic vec_t shaped_vec(vec_shape_t shape);
        vec_t        v;
        logic [63:0] span_mask;
        int          k;
        v = '0;
        case (shape)
            SHAPE_NARROW:
            begin
                k         = $urandom_range(1, 63);
                span_mask = (64'd1 << k) - 64'd1;
                v         = any_vec() & vec_t'(span_mask);
            end
            SHAPE_SPARSE:
            begin
                k = $urandom_range(1, 3);
                repeat (k)
                    v[$urandom_range(0, xlb_pkg::VAL_W - 1)] = 1'b1;
            end
            SHAPE_SPAN:
            begin
                foreach (insert_log[j])
                    if ($urandom_range(0, 1) == 1)
                        v ^= insert_log[j];
            end
            SHAPE_WIDE:
                v = any_vec();
            default:
                v = ($urandom_range(0, 1) == 1) ? '1 : '0;
        endcase
        return v;
    endfunction

    // Present one transaction and hold it until the engine takes it; then pace the next burst.
    task automatic issue(logic act, vec_t val);
        int gap;
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
            @(posedge clk);
        while (busy);
        basis_sb.note_input(act, val);
        if (act == xlb_pkg::ACT_INSERT)
        begin
            insert_log.push_back(val);
            if (insert_log.size() > SPAN_DEPTH)
                void'(insert_log.pop_front());
        end
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        // End of burst: drop start and drive noise on the payload during the gap.
        // Long gaps land on every phase of the slot walk; short ones keep the pipe busy.
        gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        burst_left = $urandom_range(0, 15);
        start <= 1'b0;
        repeat (gap)
        begin
            action <= 1'($urandom);
            value  <= any_vec();
            @(posedge clk);
        end
    endtask

    initial
    begin
        int         roll;
        logic       act;
        vec_shape_t shape;

        basis_sb = new();

        // Hold reset low from time zero, then release it at an edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions: empty basis, zero, all ones, lowest and highest slots,
        // dependent inserts, and reduces that hit and miss.
        issue(xlb_pkg::ACT_REDUCE, '0);
        issue(xlb_pkg::ACT_INSERT, '0);
        issue(xlb_pkg::ACT_REDUCE, '1);
        issue(xlb_pkg::ACT_INSERT, '1);
        issue(xlb_pkg::ACT_INSERT, '1);
        issue(xlb_pkg::ACT_REDUCE, '1);
        issue(xlb_pkg::ACT_INSERT, vec_t'(1));
        issue(xlb_pkg::ACT_INSERT, vec_t'(1) << 62);
        issue(xlb_pkg::ACT_INSERT, vec_t'({32{2'b10}}));
        issue(xlb_pkg::ACT_INSERT, vec_t'({32{2'b01}}));
        issue(xlb_pkg::ACT_REDUCE, vec_t'({32{2'b01}}));
        issue(xlb_pkg::ACT_REDUCE, vec_t'(1));
        issue(xlb_pkg::ACT_INSERT, vec_t'(2));
        issue(xlb_pkg::ACT_INSERT, vec_t'(3));
        issue(xlb_pkg::ACT_REDUCE, vec_t'(3));
        issue(xlb_pkg::ACT_INSERT, vec_t'(64'h0000_0001_0000_0000));
        issue(xlb_pkg::ACT_REDUCE, vec_t'(64'h7FFF_FFFF_0000_0000));
        issue(xlb_pkg::ACT_INSERT, '0);

        // Random transactions: mostly inserts of vectors whose leading bit spreads over all
        // slots, so the rank climbs to a full basis; then full-basis inserts and reduces.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 9);
            act  = (roll >= 6) ? xlb_pkg::ACT_REDUCE : xlb_pkg::ACT_INSERT;
            case (roll)
                0, 1, 2, 6: shape = SHAPE_NARROW;
                3:          shape = SHAPE_SPARSE;
                4, 8:       shape = SHAPE_SPAN;
                5, 7:       shape = SHAPE_WIDE;
                default:
                begin
                    shape = SHAPE_EDGE;
                    act   = ($urandom_range(0, 1) == 1) ? xlb_pkg::ACT_REDUCE
                                                        : xlb_pkg::ACT_INSERT;
                end
            endcase
            issue(act, shaped_vec(shape));
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for stray strobes over one more walk.
        while (basis_sb.pending.size() != 0)
            @(posedge clk);
        repeat (BASIS_W + 8) @(posedge clk);

        if (basis_sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xlb_pkg.sv
rtl/xlb_ctrl.sv
rtl/xlb_datapath.sv
rtl/xor_linear_basis_engine_top.sv
rtl/xlb_checker.sv
bench/tb_top.sv
